// ===== rtl/kpc_pkg.sv =====
package kpc_pkg;

  // Field widths
  localparam int unsigned PressW = 10;
  localparam int unsigned HoldW  = 8;

  // Register reset values
  localparam logic [PressW-1:0] LongPressRst  = 10'd600;
  localparam logic [PressW-1:0] ShortPressRst = 10'd10;
  localparam logic [HoldW-1:0]  LevelHoldRst  = 8'd20;

  // Configuration port
  localparam int unsigned AddrW = 4;

  typedef enum logic [1:0] {
    RegLongPress  = 2'd0,
    RegShortPress = 2'd1,
    RegLevelHold  = 2'd2
  } reg_idx_e;

  // Input item, first field in bit 3, last field in bit 0
  typedef struct packed {
    logic charging_key_level;
    logic safety_key_level;
    logic function_key_level;
    logic tick;
  } item_t;

  // Result item, first field in bit 3, last field in bit 0
  typedef struct packed {
    logic charging_active;
    logic safety_active;
    logic long_press;
    logic short_press;
  } result_t;

endpackage

// ===== rtl/key_press_classifier.sv =====
// The result register loads when an accepted input item moves on from the input register,
// which happens once the result register is free or is being emptied; m_axis_tvalid
// rises when the result register loads (input register, then result register).
// Throughput: one item per clock; a full result register that is not taken stalls the
// input register, which in turn drops s_axis_tready.
// Reset (rst_ni low, asynchronous): both registers empty, press and hold counters and
// the last function level cleared, thresholds back to 600, 10 and 20 ticks.
module key_press_classifier (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // Input stream, tdata: tick, function_key_level, safety_key_level,
  // charging_key_level, 4 bits of zero fill
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [7:0]                 s_axis_tdata,
  // Result stream, tdata: short_press, long_press, safety_active,
  // charging_active, 4 bits of zero fill
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [7:0]                 m_axis_tdata,
  // Configuration port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [kpc_pkg::AddrW-1:0]  paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import kpc_pkg::*;

  // Configuration registers
  logic [PressW-1:0] long_ticks_q, short_ticks_q;
  logic [HoldW-1:0]  hold_ticks_q;
  reg_idx_e          reg_idx;
  logic              cfg_wr;

  // Pipeline registers
  logic    in_valid_q, out_valid_q;
  item_t   in_item_q;
  result_t out_res_q, out_res_d;
  logic    advance;

  // Block state
  logic              last_level_q, last_level_d;
  logic [PressW-1:0] press_len_q, press_len_d;
  logic [HoldW-1:0]  safety_cnt_q, safety_cnt_d;
  logic [HoldW-1:0]  charge_cnt_q, charge_cnt_d;
  logic              safety_act, charge_act;

  logic [PressW:0]   press_inc;
  logic [HoldW:0]    safety_inc, charge_inc;

  // Register file access
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[AddrW-1:2]);
  assign cfg_wr  = psel & penable & pwrite;

  always_comb begin
    case (reg_idx)
      RegLongPress:  prdata = {{(32-PressW){1'b0}}, long_ticks_q};
      RegShortPress: prdata = {{(32-PressW){1'b0}}, short_ticks_q};
      RegLevelHold:  prdata = {{(32-HoldW){1'b0}}, hold_ticks_q};
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      long_ticks_q  <= LongPressRst;
      short_ticks_q <= ShortPressRst;
      hold_ticks_q  <= LevelHoldRst;
    end else if (cfg_wr) begin
      case (reg_idx)
        RegLongPress:  long_ticks_q  <= pwdata[PressW-1:0];
        RegShortPress: short_ticks_q <= pwdata[PressW-1:0];
        RegLevelHold:  hold_ticks_q  <= pwdata[HoldW-1:0];
        default: ;
      endcase
    end
  end

  // Handshake: move the input register on whenever the result register frees up
  assign advance       = in_valid_q & (~out_valid_q | m_axis_tready);
  assign s_axis_tready = ~in_valid_q | advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_item_q <= item_t'(s_axis_tdata[3:0]);
    end
  end

  // Classify the press and update the low-level counters
  assign press_inc  = {1'b0, press_len_q} + 1'b1;
  assign safety_inc = {1'b0, safety_cnt_q} + 1'b1;
  assign charge_inc = {1'b0, charge_cnt_q} + 1'b1;

  always_comb begin
    last_level_d = last_level_q;
    press_len_d  = press_len_q;
    safety_cnt_d = safety_cnt_q;
    charge_cnt_d = charge_cnt_q;
    safety_act   = 1'b0;
    charge_act   = 1'b0;
    out_res_d    = '0;
    if (in_item_q.tick) begin
      // Function key: a level change ends the press
      if (in_item_q.function_key_level != last_level_q) begin
        last_level_d = in_item_q.function_key_level;
        if (press_len_q >= long_ticks_q) begin
          out_res_d.long_press = 1'b1;
        end else if (press_len_q > short_ticks_q) begin
          out_res_d.short_press = 1'b1;
        end
        press_len_d = '0;
      end else if (!in_item_q.function_key_level) begin
        if (press_inc >= {1'b0, long_ticks_q}) begin
          press_len_d = long_ticks_q;
        end else begin
          press_len_d = press_inc[PressW-1:0];
        end
      end
      // Safety input: saturate at the hold count
      if (in_item_q.safety_key_level) begin
        safety_cnt_d = '0;
      end else if (safety_inc > {1'b0, hold_ticks_q}) begin
        safety_cnt_d = hold_ticks_q;
        safety_act   = 1'b1;
      end else begin
        safety_cnt_d = safety_inc[HoldW-1:0];
      end
      // Charging input: same rule
      if (in_item_q.charging_key_level) begin
        charge_cnt_d = '0;
      end else if (charge_inc > {1'b0, hold_ticks_q}) begin
        charge_cnt_d = hold_ticks_q;
        charge_act   = 1'b1;
      end else begin
        charge_cnt_d = charge_inc[HoldW-1:0];
      end
      out_res_d.safety_active   = safety_act;
      out_res_d.charging_active = charge_act;
    end
  end

  // Commit state together with the result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_level_q <= 1'b0;
      press_len_q  <= '0;
      safety_cnt_q <= '0;
      charge_cnt_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (advance) begin
        last_level_q <= last_level_d;
        press_len_q  <= press_len_d;
        safety_cnt_q <= safety_cnt_d;
        charge_cnt_q <= charge_cnt_d;
        out_valid_q  <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_res_q <= out_res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0000, out_res_q};

  // Checks
  a_press_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_res_q.short_press && out_res_q.long_press))
    else $error("short and long press reported together");

  a_no_tick_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && !in_item_q.tick) |=> (out_res_q == '0))
    else $error("result without tick is not zero");

  a_no_tick_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && !in_item_q.tick) |=>
      ($stable(press_len_q) && $stable(safety_cnt_q) && $stable(charge_cnt_q)))
    else $error("state changed without tick");

  a_stall_keeps_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !advance) |=> (in_valid_q && $stable(in_item_q)))
    else $error("stalled input item lost");

endmodule
